// ===== design/frl_pkg.sv =====
package frl_pkg;

    // Table and field geometry
    localparam int MAX_REGIONS = 64;
    localparam int COORD_W     = 24;
    localparam int SLOT_W      = 6;
    localparam int BAND_W      = 23;
    localparam int FIELD_W     = 32;
    localparam int SCALE_W     = 16;
    localparam int COUNT_W     = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam int ADDR_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1);

    // Squared radius widths: stored entry and query point
    localparam int R2_W = 2 * BAND_W;
    localparam int Q2_W = 2 * COORD_W;
    localparam int ZC_W = (COORD_W > BAND_W) ? COORD_W : BAND_W;
    localparam int RC_W = (Q2_W > R2_W) ? Q2_W : R2_W;

    // Shared multiplier operand widths
    localparam int MA_W = ((FIELD_W > COORD_W) ? FIELD_W : COORD_W) + 1;
    localparam int MB_W = ((COORD_W > BAND_W) ? COORD_W : BAND_W) + 1;
    localparam int MP_W = MA_W + MB_W;

    localparam int SCALE_SHIFT = 12;
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(4096);

    // Stream payload widths
    localparam int IN_FIELDS_W  = SLOT_W + 3 * COORD_W + 4 * BAND_W + 3 * FIELD_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 * FIELD_W + SLOT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Item kinds
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_SCALE  = 1'b1;

    // Multiplier sequence steps
    localparam logic [2:0] STEP_FIRST      = 3'd0;
    localparam logic [2:0] STEP_SECOND     = 3'd1;
    localparam logic [2:0] STEP_FX         = 3'd2;
    localparam logic [2:0] STEP_FY         = 3'd3;
    localparam logic [2:0] STEP_FZ         = 3'd4;
    localparam logic [2:0] STEP_LOAD_DONE  = 3'd5;
    localparam logic [2:0] STEP_QUERY_DONE = 3'd2;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL    = 5'b00010,
        S_WRITE  = 5'b00100,
        S_SCAN   = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    typedef struct packed {
        logic [BAND_W-1:0]         z_lo;
        logic [BAND_W-1:0]         z_hi;
        logic [R2_W-1:0]           r2_lo;
        logic [R2_W-1:0]           r2_hi;
        logic signed [FIELD_W-1:0] bx;
        logic signed [FIELD_W-1:0] by;
        logic signed [FIELD_W-1:0] bz;
    } t_entry;

    typedef struct packed {
        logic                      hit;
        logic signed [FIELD_W-1:0] bx;
        logic signed [FIELD_W-1:0] by;
        logic signed [FIELD_W-1:0] bz;
    } t_match;

    localparam logic signed [MP_W-1:0] SAT_HI = MP_W'({1'b0, {(FIELD_W-1){1'b1}}});
    localparam logic signed [MP_W-1:0] SAT_LO = -SAT_HI - MP_W'(1);

    // floor(p / 4096), clamped to the field range
    function automatic logic signed [FIELD_W-1:0] sat_scale(input logic signed [MP_W-1:0] p);
        logic signed [MP_W-1:0] q;
        q = p >>> SCALE_SHIFT;
        if (q > SAT_HI) begin
            return {1'b0, {(FIELD_W-1){1'b1}}};
        end else if (q < SAT_LO) begin
            return {1'b1, {(FIELD_W-1){1'b0}}};
        end else begin
            return q[FIELD_W-1:0];
        end
    endfunction

    // Negate, most negative value clamps to most positive
    function automatic logic signed [FIELD_W-1:0] neg_sat(input logic signed [FIELD_W-1:0] v);
        if (v == {1'b1, {(FIELD_W-1){1'b0}}}) begin
            return {1'b0, {(FIELD_W-1){1'b1}}};
        end else begin
            return -v;
        end
    endfunction

endpackage

// ===== design/field_region_lookup.sv =====
// Load: 6 multiplier steps, then 1 table write; no result.
// Query: the result is valid once the scan finds a hit at entry k, or after n entries on a miss,
//   n = min(region_count, MAX_REGIONS); one at a time.
// The table scan reads one entry from the region RAM per cycle.
// Reset (i_rst_n low, synchronous): all entries invalid, region_count 0, field_scale 1.0,
//   no result pending. Entry contents are not cleared, valid bits hide them.
module field_region_lookup import frl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, low bit up: region_slot, x_pos, y_pos, z_pos, band_z_low, band_z_high,
    //   radius_low, radius_high, raw_field_x, raw_field_y, raw_field_z, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: action
    input  logic                  s_axis_tuser,
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, low bit up: field_x, field_y, field_z, matched_slot, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: region_found
    output logic                  m_axis_tuser,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // tdata field offsets
    localparam int OFF_X   = SLOT_W;
    localparam int OFF_Y   = OFF_X + COORD_W;
    localparam int OFF_Z   = OFF_Y + COORD_W;
    localparam int OFF_ZLO = OFF_Z + COORD_W;
    localparam int OFF_ZHI = OFF_ZLO + BAND_W;
    localparam int OFF_RL  = OFF_ZHI + BAND_W;
    localparam int OFF_RH  = OFF_RL + BAND_W;
    localparam int OFF_FX  = OFF_RH + BAND_W;
    localparam int OFF_FY  = OFF_FX + FIELD_W;
    localparam int OFF_FZ  = OFF_FY + FIELD_W;

    t_state r_state;

    // config registers
    logic [COUNT_W-1:0] r_count;
    logic [SCALE_W-1:0] r_scale;

    // latched item
    logic                      r_action;
    logic [SLOT_W-1:0]         r_slot;
    logic [COORD_W-1:0]        r_ax, r_ay, r_az;
    logic                      r_z_neg;
    logic [BAND_W-1:0]         r_zlo, r_zhi, r_rl, r_rh;
    logic signed [FIELD_W-1:0] r_fx, r_fy, r_fz;

    // load results
    logic [R2_W-1:0]           r_r2lo, r_r2hi;
    logic signed [FIELD_W-1:0] r_bx, r_by, r_bz;

    // query state
    logic [Q2_W-1:0]  r_r2;
    logic [2:0]       r_step;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_pend;
    logic             r_rd_valid;
    logic [MAX_REGIONS-1:0] r_valid;

    // result staging and output register
    logic                      r_res_found;
    logic [SLOT_W-1:0]         r_res_slot;
    logic signed [FIELD_W-1:0] r_res_bx, r_res_by, r_res_bz;
    logic                      r_out_valid;
    logic                      r_out_found;
    logic [SLOT_W-1:0]         r_out_slot;
    logic signed [FIELD_W-1:0] r_out_bx, r_out_by, r_out_bz;

    logic                   in_fire, cfg_fire, out_free, slot_ok, issue;
    logic [COORD_W-1:0]     w_x, w_y, w_z;
    logic [CNT_W-1:0]       scan_n;
    logic signed [MA_W-1:0] w_a;
    logic signed [MB_W-1:0] w_b;
    logic signed [MP_W-1:0] w_prod;
    t_entry                 w_wentry, w_rentry;
    logic [$bits(t_entry)-1:0] w_rdata;
    t_match                 w_match;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_out_valid || m_axis_tready;

    // nothing is taken while reset is held
    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign o_cfg_ready   = i_rst_n;

    assign w_x = s_axis_tdata[OFF_X +: COORD_W];
    assign w_y = s_axis_tdata[OFF_Y +: COORD_W];
    assign w_z = s_axis_tdata[OFF_Z +: COORD_W];

    // entries searched, clamped to the table depth
    assign scan_n  = (32'(r_count) > MAX_REGIONS) ? CNT_W'(MAX_REGIONS) : CNT_W'(r_count);
    assign issue   = (r_idx < scan_n);
    assign slot_ok = (32'(r_slot) < MAX_REGIONS);

    // multiplier operand select: loads square both radii then scale three
    // field components; queries square |x| and |y|
    always_comb begin
        w_a = '0;
        w_b = '0;
        if (r_action == ACT_QUERY) begin
            case (r_step)
                STEP_FIRST: begin
                    w_a = MA_W'(r_ax);
                    w_b = MB_W'(r_ax);
                end
                STEP_SECOND: begin
                    w_a = MA_W'(r_ay);
                    w_b = MB_W'(r_ay);
                end
                default: ;
            endcase
        end else begin
            case (r_step)
                STEP_FIRST: begin
                    w_a = MA_W'(r_rl);
                    w_b = MB_W'(r_rl);
                end
                STEP_SECOND: begin
                    w_a = MA_W'(r_rh);
                    w_b = MB_W'(r_rh);
                end
                STEP_FX: begin
                    w_a = MA_W'(r_fx);
                    w_b = MB_W'(r_scale);
                end
                STEP_FY: begin
                    w_a = MA_W'(r_fy);
                    w_b = MB_W'(r_scale);
                end
                STEP_FZ: begin
                    w_a = MA_W'(r_fz);
                    w_b = MB_W'(r_scale);
                end
                default: ;
            endcase
        end
    end

    frl_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    assign w_wentry = '{
        z_lo:  r_zlo,
        z_hi:  r_zhi,
        r2_lo: r_r2lo,
        r2_hi: r_r2hi,
        bx:    r_bx,
        by:    r_by,
        bz:    r_bz
    };

    frl_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_WRITE) && slot_ok),
        .i_waddr (ADDR_W'(r_slot)),
        .i_wdata (w_wentry),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rentry = t_entry'(w_rdata);

    frl_match u_match (
        .i_entry (w_rentry),
        .i_valid (r_rd_valid),
        .i_az    (r_az),
        .i_r2    (r_r2),
        .i_z_neg (r_z_neg),
        .o_match (w_match)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_scale     <= SCALE_RESET;
        end else begin
            if (cfg_fire) begin
                unique case (i_cfg_index)
                    CFG_REGION_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_FIELD_SCALE:  r_scale <= i_cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end

            if ((r_state == S_RESULT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_step  <= STEP_FIRST;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 3'd1;
                    if ((r_action == ACT_LOAD) && (r_step == STEP_LOAD_DONE)) begin
                        r_state <= S_WRITE;
                    end else if ((r_action == ACT_QUERY) && (r_step == STEP_QUERY_DONE)) begin
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_WRITE: begin
                    if (slot_ok) begin
                        r_valid[ADDR_W'(r_slot)] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    // read of entry r_idx issues now, its compare lands next cycle
                    r_pend <= issue;
                    if (issue) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if ((r_pend && w_match.hit) || !issue) begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action <= s_axis_tuser;
            r_slot   <= s_axis_tdata[SLOT_W-1:0];
            r_ax     <= w_x[COORD_W-1] ? (~w_x + 1'b1) : w_x;
            r_ay     <= w_y[COORD_W-1] ? (~w_y + 1'b1) : w_y;
            r_az     <= w_z[COORD_W-1] ? (~w_z + 1'b1) : w_z;
            r_z_neg  <= w_z[COORD_W-1];
            r_zlo    <= s_axis_tdata[OFF_ZLO +: BAND_W];
            r_zhi    <= s_axis_tdata[OFF_ZHI +: BAND_W];
            r_rl     <= s_axis_tdata[OFF_RL +: BAND_W];
            r_rh     <= s_axis_tdata[OFF_RH +: BAND_W];
            r_fx     <= s_axis_tdata[OFF_FX +: FIELD_W];
            r_fy     <= s_axis_tdata[OFF_FY +: FIELD_W];
            r_fz     <= s_axis_tdata[OFF_FZ +: FIELD_W];
        end

        // product of the previous step arrives from the multiplier
        if (r_state == S_MUL) begin
            if (r_action == ACT_LOAD) begin
                case (r_step)
                    STEP_SECOND:    r_r2lo <= w_prod[R2_W-1:0];
                    STEP_FX:        r_r2hi <= w_prod[R2_W-1:0];
                    STEP_FY:        r_bx   <= sat_scale(w_prod);
                    STEP_FZ:        r_by   <= sat_scale(w_prod);
                    STEP_LOAD_DONE: r_bz   <= sat_scale(w_prod);
                    default: ;
                endcase
            end else begin
                case (r_step)
                    STEP_SECOND:     r_r2 <= w_prod[Q2_W-1:0];
                    STEP_QUERY_DONE: r_r2 <= r_r2 + w_prod[Q2_W-1:0];
                    default: ;
                endcase
            end
        end

        if (r_state == S_SCAN) begin
            r_rd_idx   <= r_idx;
            r_rd_valid <= r_valid[r_idx[ADDR_W-1:0]];
            if (r_pend && w_match.hit) begin
                r_res_found <= 1'b1;
                r_res_slot  <= SLOT_W'(r_rd_idx);
                r_res_bx    <= w_match.bx;
                r_res_by    <= w_match.by;
                r_res_bz    <= w_match.bz;
            end else begin
                // miss default, overwritten if a later entry hits
                r_res_found <= 1'b0;
                r_res_slot  <= '0;
                r_res_bx    <= '0;
                r_res_by    <= '0;
                r_res_bz    <= '0;
            end
        end

        if ((r_state == S_RESULT) && out_free) begin
            r_out_found <= r_res_found;
            r_out_slot  <= r_res_slot;
            r_out_bx    <= r_res_bx;
            r_out_by    <= r_res_by;
            r_out_bz    <= r_res_bz;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_slot, r_out_bz, r_out_by, r_out_bx});

endmodule

// ===== design/frl_ram.sv =====
module frl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/frl_mul.sv =====
module frl_mul import frl_pkg::*; (
    input  logic                   i_clk,
    input  logic signed [MA_W-1:0] i_a,
    input  logic signed [MB_W-1:0] i_b,
    output logic signed [MP_W-1:0] o_prod
);

    logic signed [MP_W-1:0] r_prod;

    // one product per cycle, registered
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== design/frl_match.sv =====
module frl_match import frl_pkg::*; (
    input  t_entry             i_entry,
    input  logic               i_valid,
    input  logic [COORD_W-1:0] i_az,
    input  logic [Q2_W-1:0]    i_r2,
    input  logic               i_z_neg,
    output t_match             o_match
);

    logic [ZC_W-1:0] az, zlo, zhi;
    logic [RC_W-1:0] r2, rlo, rhi;

    assign az  = ZC_W'(i_az);
    assign zlo = ZC_W'(i_entry.z_lo);
    assign zhi = ZC_W'(i_entry.z_hi);
    assign r2  = RC_W'(i_r2);
    assign rlo = RC_W'(i_entry.r2_lo);
    assign rhi = RC_W'(i_entry.r2_hi);

    // low bounds inclusive, high bounds exclusive
    assign o_match.hit = i_valid && (zlo <= az) && (az < zhi) && (rlo <= r2) && (r2 < rhi);
    assign o_match.bx  = i_z_neg ? neg_sat(i_entry.bx) : i_entry.bx;
    assign o_match.by  = i_z_neg ? neg_sat(i_entry.by) : i_entry.by;
    assign o_match.bz  = i_entry.bz;

endmodule

// ===== design/frl_checker.sv =====
module frl_checker import frl_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a miss carries zero field and slot
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("miss result with nonzero payload");

    // block is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after an input transfer");

    // a new result only appears out of a busy cycle
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind field_region_lookup frl_checker u_frl_checker (.*);

// ===== bench/field_region_lookup_tb.sv =====
`timescale 1ns / 100ps

// Checks the cylindrical field region table: loads and queries go in on the input
// stream, every query result is compared field by field against a typed answer or
// a local model of the table. A short table of directed rows comes first, then
// random traffic over several register settings, with random gaps on both streams.
module field_region_lookup_tb;
    import frl_pkg::*;

    localparam int COORD_MAX = 8388607;
    localparam int DRAIN_TAIL = 80;      // longer than the slowest query

    // One input item, all fields present whatever the action
    typedef struct {
        logic                      act;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [BAND_W-1:0]         zlo;
        logic [BAND_W-1:0]         zhi;
        logic [BAND_W-1:0]         rlo;
        logic [BAND_W-1:0]         rhi;
        logic signed [FIELD_W-1:0] fx;
        logic signed [FIELD_W-1:0] fy;
        logic signed [FIELD_W-1:0] fz;
    } stim_t;

    // One query answer
    typedef struct {
        logic signed [FIELD_W-1:0] bx;
        logic signed [FIELD_W-1:0] by;
        logic signed [FIELD_W-1:0] bz;
        logic                      found;
        logic [SLOT_W-1:0]         slot;
    } field_res_t;

    typedef enum {ROW_WRITE, ROW_ITEM} row_kind_e;

    // Directed plan row: a register write or an item, with an optional typed answer
    typedef struct {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        stim_t                 item;
        bit                    typed;
        field_res_t            want;
    } plan_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Local copy of the region table and registers
    bit                        tbl_valid [MAX_REGIONS];
    longint                    tbl_zlo   [MAX_REGIONS];
    longint                    tbl_zhi   [MAX_REGIONS];
    longint                    tbl_r2lo  [MAX_REGIONS];
    longint                    tbl_r2hi  [MAX_REGIONS];
    int                        tbl_rlo   [MAX_REGIONS];   // raw radii, used to aim queries
    int                        tbl_rhi   [MAX_REGIONS];
    logic signed [FIELD_W-1:0] tbl_bx    [MAX_REGIONS];
    logic signed [FIELD_W-1:0] tbl_by    [MAX_REGIONS];
    logic signed [FIELD_W-1:0] tbl_bz    [MAX_REGIONS];
    int                        cur_count;
    int                        cur_scale;

    field_res_t field_q[$];      // answers still owed by the block
    plan_row_t  plan[$];
    field_res_t mon_got;
    field_res_t mon_want;
    field_res_t MISS;
    int         err_cnt;
    int         results_seen;
    int         calm_left;

    field_region_lookup uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit, several times the slowest legal run
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Model of the table
    // ---------------------------------------------------------------

    // raw * scale in Q4.12, floor, clamped to 32 bits
    function automatic logic signed [FIELD_W-1:0] scaled(input logic signed [FIELD_W-1:0] raw);
        longint p;
        longint q;
        p = longint'(raw) * longint'(cur_scale);
        q = p >>> 12;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return FIELD_W'(q);
    endfunction

    // Negation where the most negative value clamps to the most positive
    function automatic logic signed [FIELD_W-1:0] flip_sat(input logic signed [FIELD_W-1:0] v);
        if (v == 32'sh8000_0000) return 32'sh7FFF_FFFF;
        return -v;
    endfunction

    function automatic void store_region(input stim_t it);
        int s;
        s = it.slot;
        tbl_zlo[s]   = longint'(it.zlo);
        tbl_zhi[s]   = longint'(it.zhi);
        tbl_r2lo[s]  = longint'(it.rlo) * longint'(it.rlo);
        tbl_r2hi[s]  = longint'(it.rhi) * longint'(it.rhi);
        tbl_rlo[s]   = it.rlo;
        tbl_rhi[s]   = it.rhi;
        tbl_bx[s]    = scaled(it.fx);
        tbl_by[s]    = scaled(it.fy);
        tbl_bz[s]    = scaled(it.fz);
        tbl_valid[s] = 1'b1;
    endfunction

    // First valid entry below the search count whose band and ring hold the point
    function automatic field_res_t lookup_field(input stim_t it);
        field_res_t r;
        longint     xs, ys, zs, r2, az;
        int         n;
        r = MISS;
        xs = it.x;
        ys = it.y;
        zs = it.z;
        r2 = xs * xs + ys * ys;
        az = (zs < 0) ? -zs : zs;
        n = (cur_count > MAX_REGIONS) ? MAX_REGIONS : cur_count;
        for (int i = 0; i < n; i++) begin
            if (!r.found && tbl_valid[i] &&
                tbl_zlo[i] <= az && az < tbl_zhi[i] &&
                tbl_r2lo[i] <= r2 && r2 < tbl_r2hi[i]) begin
                r.found = 1'b1;
                r.slot  = SLOT_W'(i);
                r.bx    = (zs < 0) ? flip_sat(tbl_bx[i]) : tbl_bx[i];
                r.by    = (zs < 0) ? flip_sat(tbl_by[i]) : tbl_by[i];
                r.bz    = tbl_bz[i];
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic field_res_t mk_res(input logic signed [FIELD_W-1:0] bx,
                                          input logic signed [FIELD_W-1:0] by,
                                          input logic signed [FIELD_W-1:0] bz,
                                          input logic found, input int slot);
        field_res_t r;
        r.bx = bx;
        r.by = by;
        r.bz = bz;
        r.found = found;
        r.slot = SLOT_W'(slot);
        return r;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_item(input stim_t it);
        return IN_DATA_W'({it.fz, it.fy, it.fx, it.rhi, it.rlo, it.zhi, it.zlo,
                           it.z, it.y, it.x, it.slot});
    endfunction

    // Every field random; loads and queries then overwrite what they use
    function automatic stim_t noise_item();
        stim_t it;
        it.act  = 1'($urandom);
        it.slot = SLOT_W'($urandom);
        it.x    = COORD_W'($urandom);
        it.y    = COORD_W'($urandom);
        it.z    = COORD_W'($urandom);
        it.zlo  = BAND_W'($urandom);
        it.zhi  = BAND_W'($urandom);
        it.rlo  = BAND_W'($urandom);
        it.rhi  = BAND_W'($urandom);
        it.fx   = $urandom;
        it.fy   = $urandom;
        it.fz   = $urandom;
        return it;
    endfunction

    function automatic logic signed [FIELD_W-1:0] field_pick();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0;
            3: return -32'sh1;
            default: return $urandom;
        endcase
    endfunction

    // Value in [lo, hi), edges favored, now and then just past the top
    function automatic int pick_in(input int lo, input int hi);
        case ($urandom_range(0, 19))
            0: return lo;
            1: return hi - 1;
            2: return hi;
            default: return $urandom_range(lo, hi - 1);
        endcase
    endfunction

    function automatic stim_t load_item();
        stim_t it;
        int    n, sh, zl, rl;
        it = noise_item();
        it.act = ACT_LOAD;
        n = (cur_count > MAX_REGIONS) ? MAX_REGIONS : cur_count;
        // keep most loads inside the searched range
        if (n > 0 && $urandom_range(0, 99) < 70) it.slot = SLOT_W'($urandom_range(0, n - 1));
        sh = $urandom_range(0, 99);
        if (sh < 80) begin
            zl = $urandom_range(0, 8000000);
            rl = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 2000000);
            it.zlo = BAND_W'(zl);
            it.zhi = BAND_W'((zl + $urandom_range(1, 400000) > COORD_MAX) ?
                             COORD_MAX : zl + $urandom_range(1, 400000));
            it.rlo = BAND_W'(rl);
            it.rhi = BAND_W'((rl + $urandom_range(1, 3000000) > COORD_MAX) ?
                             COORD_MAX : rl + $urandom_range(1, 3000000));
        end else if (sh < 92) begin
            // random bounds: mostly wide or inverted
        end else begin
            it.zlo = '0;
            it.zhi = BAND_W'(COORD_MAX);
            it.rhi = BAND_W'(COORD_MAX);
        end
        if ($urandom_range(0, 4) == 0) it.fx = field_pick();
        if ($urandom_range(0, 4) == 0) it.fy = field_pick();
        if ($urandom_range(0, 4) == 0) it.fz = field_pick();
        return it;
    endfunction

    // Query aimed into a loaded entry that the scan can reach
    function automatic stim_t aim_query();
        stim_t it;
        int    cand[$];
        int    n, k, az, r;
        it = noise_item();
        it.act = ACT_QUERY;
        n = (cur_count > MAX_REGIONS) ? MAX_REGIONS : cur_count;
        for (int i = 0; i < n; i++)
            if (tbl_valid[i]) cand.insert(cand.size(), i);
        if (cand.size() > 0) begin
            k = cand[$urandom_range(0, cand.size() - 1)];
            az = (tbl_zlo[k] < tbl_zhi[k]) ? pick_in(int'(tbl_zlo[k]), int'(tbl_zhi[k]))
                                           : $urandom_range(0, COORD_MAX);
            r = (tbl_rlo[k] < tbl_rhi[k]) ? pick_in(tbl_rlo[k], tbl_rhi[k])
                                         : $urandom_range(0, COORD_MAX);
            it.z = COORD_W'($urandom_range(0, 1) ? -az : az);
            if ($urandom_range(0, 1)) begin
                it.x = COORD_W'($urandom_range(0, 1) ? -r : r);
                it.y = '0;
            end else begin
                it.x = '0;
                it.y = COORD_W'($urandom_range(0, 1) ? -r : r);
            end
        end
        return it;
    endfunction

    // Unaimed query: full range, or near the axis
    function automatic stim_t noise_query();
        stim_t it;
        it = noise_item();
        it.act = ACT_QUERY;
        if ($urandom_range(0, 3) == 0) begin
            it.x = COORD_W'(int'($urandom_range(0, 127)) - 64);
            it.y = COORD_W'(int'($urandom_range(0, 127)) - 64);
            it.z = COORD_W'(int'($urandom_range(0, 127)) - 64);
        end
        return it;
    endfunction

    function automatic int pick_gap();
        int r, g;
        r = $urandom_range(0, 99);
        g = 0;
        if (calm_left > 0) calm_left--;
        else if (r < 2) calm_left = $urandom_range(10, 40);
        else if (r < 55) g = 0;
        else if (r < 88) g = $urandom_range(1, 3);
        else if (r < 97) g = $urandom_range(4, 12);
        else g = $urandom_range(20, 60);
        return g;
    endfunction

    // Directed plan builders
    function automatic void tab_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        plan_row_t row;
        row.kind = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = CFG_DATA_W'(val);
        row.typed = 1'b0;
        plan.insert(plan.size(), row);
    endfunction

    function automatic void tab_load(input int slot, input int zlo, input int zhi,
                                     input int rlo, input int rhi,
                                     input logic signed [FIELD_W-1:0] fx,
                                     input logic signed [FIELD_W-1:0] fy,
                                     input logic signed [FIELD_W-1:0] fz);
        plan_row_t row;
        row.kind = ROW_ITEM;
        row.item = noise_item();
        row.item.act = ACT_LOAD;
        row.item.slot = SLOT_W'(slot);
        row.item.zlo = BAND_W'(zlo);
        row.item.zhi = BAND_W'(zhi);
        row.item.rlo = BAND_W'(rlo);
        row.item.rhi = BAND_W'(rhi);
        row.item.fx = fx;
        row.item.fy = fy;
        row.item.fz = fz;
        row.typed = 1'b0;
        plan.insert(plan.size(), row);
    endfunction

    function automatic void tab_query(input int x, input int y, input int z,
                                      input bit typed, input field_res_t want);
        plan_row_t row;
        row.kind = ROW_ITEM;
        row.item = noise_item();
        row.item.act = ACT_QUERY;
        row.item.x = COORD_W'(x);
        row.item.y = COORD_W'(y);
        row.item.z = COORD_W'(z);
        row.typed = typed;
        row.want = want;
        plan.insert(plan.size(), row);
    endfunction

    // ---------------------------------------------------------------
    // Stream and register drivers
    // ---------------------------------------------------------------

    // One input transfer; the answer is owed from the edge it is taken
    task automatic send_item(input stim_t it, input bit typed, input field_res_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.act;
        s_axis_tdata  <= pack_item(it);
        @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready)) @(posedge i_clk);
        if (it.act == ACT_LOAD) store_region(it);
        else if (typed) field_q.insert(field_q.size(), want);
        else field_q.insert(field_q.size(), lookup_field(it));
    endtask

    // Wait until every answer is in and the last load has surely retired
    task automatic drain();
        int guard;
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (field_q.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // Register write, only with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready)) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_REGION_COUNT) cur_count = val[COUNT_W-1:0];
        else if (idx == CFG_FIELD_SCALE) cur_scale = val;
    endtask

    task automatic check_field(input string what, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, exp, act);
            err_cnt++;
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: ready with random stalls, one long hold-off
    // ---------------------------------------------------------------
    initial begin
        int run, stall;
        bit held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 16);
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
            if (!held && results_seen >= 400) begin
                // long hold-off: the block must back up and stall its input
                stall = 600;
                held = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: stall = 0;
                    3, 4, 5, 6, 7: stall = $urandom_range(1, 4);
                    8: stall = $urandom_range(5, 20);
                    default: stall = ($urandom_range(0, 2) == 0) ? $urandom_range(30, 80)
                                                                : $urandom_range(1, 3);
                endcase
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Result monitor: each output transfer against the oldest owed answer
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            mon_got.bx    = m_axis_tdata[31:0];
            mon_got.by    = m_axis_tdata[63:32];
            mon_got.bz    = m_axis_tdata[95:64];
            mon_got.slot  = m_axis_tdata[96 +: SLOT_W];
            mon_got.found = m_axis_tuser;
            if (field_q.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %h/%h/%h found %b slot %0d",
                         $time, mon_got.bx, mon_got.by, mon_got.bz, mon_got.found, mon_got.slot);
                err_cnt++;
            end else begin
                mon_want = field_q.pop_front();
                check_field("field_x", mon_want.bx, mon_got.bx);
                check_field("field_y", mon_want.by, mon_got.by);
                check_field("field_z", mon_want.bz, mon_got.bz);
                check_field("region_found", 32'(mon_want.found), 32'(mon_got.found));
                check_field("matched_slot", 32'(mon_want.slot), 32'(mon_got.slot));
            end
            results_seen++;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int    ph, n;
        int    cnt_list[7];
        int    scl_list[7];
        stim_t it;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        err_cnt = 0;
        results_seen = 0;
        calm_left = 0;
        cur_count = 0;
        cur_scale = 4096;
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        MISS = mk_res(0, 0, 0, 1'b0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows. Counts and scales in the typed answers are the ones in force.
        // After reset nothing is searched
        tab_query(COORD_MAX, -8388608, -8388608, 1'b1, MISS);
        tab_write(CFG_REGION_COUNT, 64);
        tab_load(0, 0, 100, 0, 10, 1000, -2000, 3000);
        tab_query(3, 4, 50, 1'b1, mk_res(1000, -2000, 3000, 1'b1, 0));
        // below z = 0 the transverse parts flip
        tab_query(-3, -4, -50, 1'b1, mk_res(-1000, 2000, 3000, 1'b1, 0));
        // upper radius and upper band are exclusive, lower ones inclusive
        tab_query(6, 8, 0, 1'b1, MISS);
        tab_query(0, 0, 100, 1'b1, MISS);
        tab_query(0, 0, 0, 1'b1, mk_res(1000, -2000, 3000, 1'b1, 0));
        // widest entry in the last slot, extreme field values
        tab_load(63, 0, COORD_MAX, 0, COORD_MAX, 32'sh7FFF_FFFF, 32'sh8000_0000, -1);
        // flipping the most negative field clamps to the most positive
        tab_query(20, 0, -5, 1'b1, mk_res(32'sh8000_0001, 32'sh7FFF_FFFF, -1, 1'b1, 63));
        tab_query(-8388608, -8388608, COORD_MAX, 1'b1, MISS);
        tab_query(COORD_MAX, 0, -8388608, 1'b1, MISS);
        // inverted band and empty ring never match
        tab_load(1, 50, 10, 0, 100, 11, 22, 33);
        tab_load(2, 0, 1000, 5, 5, 44, 55, 66);
        tab_query(50, 0, 30, 1'b0, MISS);
        // full-scale multiplier saturates both ways
        tab_write(CFG_FIELD_SCALE, 65535);
        tab_load(3, 1000, 2000, 0, 100, 32'sh7FFF_FFFF, 32'sh8000_0000, 4096);
        tab_query(0, 0, 1500, 1'b1, mk_res(32'sh7FFF_FFFF, 32'sh8000_0000, 65535, 1'b1, 3));
        tab_write(CFG_FIELD_SCALE, 0);
        tab_load(4, 3000, 4000, 0, 1, $urandom, $urandom, $urandom);
        tab_query(0, 0, -3500, 1'b1, mk_res(0, 0, 0, 1'b1, 4));
        // smallest scale: floor rounds toward minus infinity
        tab_write(CFG_FIELD_SCALE, 1);
        tab_load(5, 5000, 6000, 0, 2, -1, 4095, 4097);
        tab_query(1, 1, 5000, 1'b1, mk_res(-1, 0, 1, 1'b1, 5));
        // count above the table size searches the whole table
        tab_write(CFG_REGION_COUNT, 100);
        tab_query(20, 0, -5, 1'b0, MISS);
        tab_write(CFG_REGION_COUNT, 5);
        tab_query(0, 0, 1500, 1'b1, mk_res(32'sh7FFF_FFFF, 32'sh8000_0000, 65535, 1'b1, 3));
        tab_query(0, 0, 5500, 1'b1, MISS);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) write_reg(plan[i].reg_idx, plan[i].reg_val);
            else send_item(plan[i].item, plan[i].typed, plan[i].want);
        end

        // Random traffic over several settings, the extremes among them
        cnt_list = '{64, 127, 1, $urandom_range(0, 127), 0, 33, 64};
        scl_list = '{4096, 65535, $urandom_range(0, 65535), 2048, 0, 1, $urandom_range(0, 65535)};
        for (ph = 0; ph < 7; ph++) begin
            // bits above the count width are don't-care
            write_reg(CFG_REGION_COUNT, {9'($urandom), 7'(cnt_list[ph])});
            write_reg(CFG_FIELD_SCALE, CFG_DATA_W'(scl_list[ph]));
            for (n = 0; n < 175; n++) begin
                if ($urandom_range(0, 99) < 35) it = load_item();
                else if ($urandom_range(0, 99) < 65) it = aim_query();
                else it = noise_query();
                send_item(it, 1'b0, MISS);
            end
        end

        drain();
        if (field_q.size() != 0) begin
            $display("%0t ns: results missing, expected %0d more, actual 0",
                     $time, field_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
